/* hw/rtl/xsb_pkg.sv */
// Shared constants, tables and helpers for the box stream cipher unit.
// Used by the channel interfaces and the top level; depends on nothing.
package xsb_pkg;

	localparam int WORD_W = 64;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 3;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_SECRET0 = 3'd0,
		CFG_SECRET1 = 3'd1,
		CFG_SECRET2 = 3'd2,
		CFG_SECRET3 = 3'd3,
		CFG_NONCE0  = 3'd4,
		CFG_NONCE1  = 3'd5,
		CFG_NONCE2  = 3'd6
	} cfg_reg_t;

	typedef logic [3:0] xidx_t;

	// Word indexes a, b, c, d of the eight quarter rounds of a double round
	localparam xidx_t QR_IDX [8][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1},
		'{4'd10, 4'd14, 4'd2,  4'd6},
		'{4'd15, 4'd3,  4'd7,  4'd11},
		'{4'd0,  4'd1,  4'd2,  4'd3},
		'{4'd5,  4'd6,  4'd7,  4'd4},
		'{4'd10, 4'd11, 4'd8,  4'd9},
		'{4'd15, 4'd12, 4'd13, 4'd14}
	};

	// Matrix words that form the HSalsa20 output key, in key order
	localparam xidx_t HOUT_IDX [8] = '{4'd0, 4'd5, 4'd10, 4'd15, 4'd6, 4'd7, 4'd8, 4'd9};

	// Rotate left by the amount of quarter-round step s (7, 9, 13, 18)
	function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] s);
		logic [31:0] r;
		unique case (s)
			2'd0: r = {v[24:0], v[31:25]};
			2'd1: r = {v[22:0], v[31:23]};
			2'd2: r = {v[18:0], v[31:19]};
			2'd3: r = {v[13:0], v[31:14]};
		endcase
		return r;
	endfunction

	// Initial matrix word i from key k (8 x 32) and middle words m (4 x 32)
	function automatic logic [31:0] matrix_word(input xidx_t i, input logic [255:0] k,
		input logic [127:0] m);
		logic [31:0] r;
		unique case (i)
			4'd0:  r = SIGMA0;
			4'd1:  r = k[31:0];
			4'd2:  r = k[63:32];
			4'd3:  r = k[95:64];
			4'd4:  r = k[127:96];
			4'd5:  r = SIGMA1;
			4'd6:  r = m[31:0];
			4'd7:  r = m[63:32];
			4'd8:  r = m[95:64];
			4'd9:  r = m[127:96];
			4'd10: r = SIGMA2;
			4'd11: r = k[159:128];
			4'd12: r = k[191:160];
			4'd13: r = k[223:192];
			4'd14: r = k[255:224];
			4'd15: r = SIGMA3;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/xsb_if.sv */
// Valid/ready channel interfaces of the box stream cipher unit.
// Depends on xsb_pkg for the field widths.

interface xsb_in_if import xsb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data_word;
	logic [CNT_W-1:0]  byte_count;
	logic              last_word;

	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface xsb_out_if import xsb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_word;
	logic [CNT_W-1:0]  result_count;
	logic              result_last;

	modport source (output valid, result_word, result_count, result_last, input ready);
	modport sink   (input valid, result_word, result_count, result_last, output ready);
endinterface

interface xsb_cfg_if import xsb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [WORD_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/xsalsa20_box_stream_cipher_unit.sv */
// XSalsa20 box stream cipher unit: XORs message words with keystream.
// Depends on xsb_pkg and the channel interfaces in xsb_if.sv.
//
// Usage:
//   cfg     : register writes (secret words 0..3, nonce words 0..2), always ready.
//             Write only while the unit is idle.
//   message : input items of 8 bytes, byte_count and last_word. Ready only
//             while the sequencer is idle.
//   result  : one output item per input item, from an output register, so a
//             new item is taken while a result waits for the receiver.
// Flow: a word in an open block is accepted in idle, then emitted once the
//   result register frees. All block math runs on one 32-bit add/rotate/xor
//   unit over a 16-word state memory with two read ports; a quarter-round
//   step reads, adds, then xors. A keystream block is load, Salsa20/20 core,
//   feed-forward; an HSalsa20 is load, core, key output. The first word of a
//   message waits for two HSalsa20 runs and one keystream block; the fourth
//   word of a message and every eighth word after it start a new block, so
//   the next item waits for that block.
// Reset clears config registers, key, counter and position; no message is open.
// A stalled receiver holds the result register; at most one more item is
// taken and held until the register frees.
module xsalsa20_box_stream_cipher_unit import xsb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xsb_cfg_if.sink   cfg,
	xsb_in_if.sink    message,
	xsb_out_if.source result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EMIT,
		ST_LOAD,
		ST_ROUND,
		ST_HOUT,
		ST_FEED
	} state_t;

	typedef enum logic [1:0] {
		MD_HS1,
		MD_HS2,
		MD_BLOCK
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [3:0]        idx_q;
	logic [1:0]        ph_q;
	logic [1:0]        step_q;
	logic [2:0]        qr_q;
	logic [3:0]        rnd_q;
	logic              opening_q;
	logic              in_msg_q;
	logic [2:0]        wpos_q;
	logic [31:0]       bctr_q;

	logic [3:0][WORD_W-1:0] secret_q;
	logic [2:0][WORD_W-1:0] nonce_q;
	logic [3:0][WORD_W-1:0] mkey_q;
	logic [7:0][WORD_W-1:0] ks_q;

	logic [WORD_W-1:0] item_word_q;
	logic [CNT_W-1:0]  item_cnt_q;
	logic              item_last_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;

	logic [31:0]       sum_q;
	logic [31:0]       state_mem_q [16];
	logic [31:0]       rd_a_q;
	logic [31:0]       rd_b_q;

	logic [255:0]      key_sel;
	logic [127:0]      mid_sel;
	logic [31:0]       init_word;
	xidx_t             qv [4];
	xidx_t             op_p;
	xidx_t             op_q;
	xidx_t             op_t;
	xidx_t             raddr_a;
	logic              mem_we;
	xidx_t             mem_waddr;
	logic [31:0]       mem_wdata;
	logic [CNT_W-1:0]  cnt_eff;
	logic [WORD_W-1:0] byte_mask;
	logic              out_free;
	logic              accept;

	// Select key and middle words of the matrix being built
	always_comb begin
		key_sel = (mode_q == MD_HS1) ? secret_q : mkey_q;
		unique case (mode_q)
			MD_HS1:  mid_sel = '0;
			MD_HS2:  mid_sel = {nonce_q[1], nonce_q[0]};
			default: mid_sel = {32'd0, bctr_q, nonce_q[2]};
		endcase
	end

	assign init_word = matrix_word(idx_q, key_sel, mid_sel);

	// Operands of the current quarter-round step
	assign qv   = QR_IDX[qr_q];
	assign op_p = qv[step_q];
	assign op_q = qv[step_q + 2'd3];
	assign op_t = qv[step_q + 2'd1];

	// Drive state memory ports from the sequencer
	always_comb begin
		raddr_a   = idx_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = init_word;
		unique case (state_q)
			ST_LOAD: begin
				mem_we = 1'b1;
			end
			ST_ROUND: begin
				raddr_a   = (ph_q == 2'd0) ? op_p : op_t;
				mem_we    = (ph_q == 2'd2);
				mem_waddr = op_t;
				mem_wdata = rd_a_q ^ rotl_step(sum_q, step_q);
			end
			ST_HOUT: begin
				raddr_a = HOUT_IDX[idx_q[2:0]];
			end
			default: begin
				raddr_a = idx_q;
			end
		endcase
	end

	// State memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= state_mem_q[raddr_a];
		rd_b_q <= state_mem_q[op_q];
	end

	// Clamp the byte count and build the byte mask
	always_comb begin
		cnt_eff = (item_cnt_q == '0 || item_cnt_q > CNT_W'(8)) ? CNT_W'(8) : item_cnt_q;
		for (int j = 0; j < 8; j++) begin
			byte_mask[8*j +: 8] = {8{CNT_W'(j) < cnt_eff}};
		end
	end

	assign out_free = !out_valid_q || result.ready;
	assign accept   = message.valid && (state_q == ST_IDLE);

	// Channel outputs
	assign message.ready       = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.result_word  = out_word_q;
	assign result.result_count = out_cnt_q;
	assign result.result_last  = out_last_q;
	assign cfg.ready           = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_q <= '0;
			nonce_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SECRET0: secret_q[0] <= cfg.data;
				CFG_SECRET1: secret_q[1] <= cfg.data;
				CFG_SECRET2: secret_q[2] <= cfg.data;
				CFG_SECRET3: secret_q[3] <= cfg.data;
				CFG_NONCE0:  nonce_q[0]  <= cfg.data;
				CFG_NONCE1:  nonce_q[1]  <= cfg.data;
				CFG_NONCE2:  nonce_q[2]  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Datapath registers without reset: item, step sum, keystream buffer
	always_ff @(posedge clk) begin
		if (accept) begin
			item_word_q <= message.data_word;
			item_cnt_q  <= message.byte_count;
			item_last_q <= message.last_word;
		end
		if (state_q == ST_ROUND && ph_q == 2'd1) begin
			sum_q <= rd_a_q + rd_b_q;
		end
		if (state_q == ST_FEED && ph_q[0]) begin
			if (idx_q[0]) begin
				ks_q[idx_q[3:1]][63:32] <= rd_a_q + init_word;
			end else begin
				ks_q[idx_q[3:1]][31:0] <= rd_a_q + init_word;
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_HS1;
			idx_q       <= '0;
			ph_q        <= '0;
			step_q      <= '0;
			qr_q        <= '0;
			rnd_q       <= '0;
			opening_q   <= 1'b0;
			in_msg_q    <= 1'b0;
			wpos_q      <= '0;
			bctr_q      <= '0;
			mkey_q      <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// load a new result, else drop the one taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (message.valid) begin
						if (in_msg_q) begin
							state_q <= ST_EMIT;
						end else begin
							opening_q <= 1'b1;
							mode_q    <= MD_HS1;
							idx_q     <= '0;
							state_q   <= ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_word_q  <= (item_word_q ^ ks_q[wpos_q]) & byte_mask;
						out_cnt_q   <= cnt_eff;
						out_last_q  <= item_last_q;
						wpos_q      <= wpos_q + 3'd1;
						if (item_last_q) begin
							in_msg_q <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (wpos_q == 3'd7) begin
							// buffer used up: compute the next block
							opening_q <= 1'b0;
							mode_q    <= MD_BLOCK;
							idx_q     <= '0;
							state_q   <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LOAD: begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd15) begin
						ph_q    <= '0;
						step_q  <= '0;
						qr_q    <= '0;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					// read operands, add, then xor the rotated sum into the target
					if (ph_q == 2'd2) begin
						ph_q   <= '0;
						step_q <= step_q + 2'd1;
						if (step_q == 2'd3) begin
							qr_q <= qr_q + 3'd1;
							if (qr_q == 3'd7) begin
								rnd_q <= rnd_q + 4'd1;
								if (rnd_q == 4'd9) begin
									idx_q   <= '0;
									state_q <= (mode_q == MD_BLOCK) ? ST_FEED : ST_HOUT;
								end
							end
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_HOUT: begin
					if (ph_q[0]) begin
						ph_q <= '0;
						if (idx_q[0]) begin
							mkey_q[idx_q[2:1]][63:32] <= rd_a_q;
						end else begin
							mkey_q[idx_q[2:1]][31:0] <= rd_a_q;
						end
						if (idx_q == 4'd7) begin
							idx_q   <= '0;
							state_q <= ST_LOAD;
							if (mode_q == MD_HS1) begin
								mode_q <= MD_HS2;
							end else begin
								mode_q <= MD_BLOCK;
								bctr_q <= '0;
							end
						end else begin
							idx_q <= idx_q + 4'd1;
						end
					end else begin
						ph_q <= 2'd1;
					end
				end
				ST_FEED: begin
					if (ph_q[0]) begin
						ph_q  <= '0;
						idx_q <= idx_q + 4'd1;
						if (idx_q == 4'd15) begin
							bctr_q <= bctr_q + 32'd1;
							if (opening_q) begin
								// skip the MAC key half of block zero
								opening_q <= 1'b0;
								wpos_q    <= 3'd4;
								in_msg_q  <= 1'b1;
								state_q   <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						ph_q <= 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking bench for the XSalsa20 box stream cipher unit: random and
// directed messages, register writes between them, result stream compared.
// Depends on xsb_pkg, the channel interfaces and the top level RTL.
`timescale 1ns / 1ps

import xsb_pkg::*;

typedef struct packed {
	logic [WORD_W-1:0] word;
	logic [CNT_W-1:0]  count;
	logic              last;
} cipher_word_t;

// Tracks secret, nonce and keystream state; holds the cipher words still owed
class keystream_scoreboard;
	bit [63:0]    secret_q [4];
	bit [63:0]    nonce_q [3];
	bit [63:0]    subkey [4];
	bit [63:0]    stream_blk [8];
	bit [31:0]    next_ctr;
	bit [2:0]     word_pos;
	bit           msg_open;
	bit [31:0]    st [16];
	cipher_word_t owed_q [$];
	int           errors;
	int           checked;

	function void set_reg(cfg_reg_t idx, bit [63:0] v);
		case (idx)
			CFG_SECRET0: secret_q[0] = v;
			CFG_SECRET1: secret_q[1] = v;
			CFG_SECRET2: secret_q[2] = v;
			CFG_SECRET3: secret_q[3] = v;
			CFG_NONCE0:  nonce_q[0] = v;
			CFG_NONCE1:  nonce_q[1] = v;
			CFG_NONCE2:  nonce_q[2] = v;
			default: ;
		endcase
	endfunction

	function bit [31:0] rotl(bit [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function void qround(int a, int b, int c, int d);
		st[b] ^= rotl(st[a] + st[d], 7);
		st[c] ^= rotl(st[b] + st[a], 9);
		st[d] ^= rotl(st[c] + st[b], 13);
		st[a] ^= rotl(st[d] + st[c], 18);
	endfunction

	// Ten column/row double rounds
	function void rounds20();
		for (int r = 0; r < 10; r++) begin
			qround(0, 4, 8, 12);
			qround(5, 9, 13, 1);
			qround(10, 14, 2, 6);
			qround(15, 3, 7, 11);
			qround(0, 1, 2, 3);
			qround(5, 6, 7, 4);
			qround(10, 11, 8, 9);
			qround(15, 12, 13, 14);
		end
	endfunction

	// Constants on the diagonal, key around them, 16-byte middle in words 6..9
	function void load_state(bit [63:0] k [4], bit [127:0] mid);
		st[0]  = SIGMA0;
		st[5]  = SIGMA1;
		st[10] = SIGMA2;
		st[15] = SIGMA3;
		for (int i = 0; i < 4; i++) begin
			st[1 + i]  = k[i / 2][32 * (i % 2) +: 32];
			st[11 + i] = k[2 + i / 2][32 * (i % 2) +: 32];
			st[6 + i]  = mid[32 * i +: 32];
		end
	endfunction

	function void hsalsa(bit [63:0] k [4], bit [127:0] mid, output bit [63:0] o [4]);
		load_state(k, mid);
		rounds20();
		o[0] = {st[5], st[0]};
		o[1] = {st[15], st[10]};
		o[2] = {st[7], st[6]};
		o[3] = {st[9], st[8]};
	endfunction

	// Compute one keystream block; the counter high word is always zero
	function void refill(bit [31:0] ctr);
		bit [31:0] init [16];
		load_state(subkey, {32'd0, ctr, nonce_q[2]});
		init = st;
		rounds20();
		for (int i = 0; i < 16; i++)
			st[i] += init[i];
		for (int i = 0; i < 8; i++)
			stream_blk[i] = {st[2 * i + 1], st[2 * i]};
	endfunction

	// Derive the message subkey and skip the MAC half of block 0
	function void open_msg();
		bit [63:0] mid_key [4];
		hsalsa(secret_q, 128'd0, mid_key);
		hsalsa(mid_key, {nonce_q[1], nonce_q[0]}, subkey);
		refill(32'd0);
		next_ctr = 32'd1;
		word_pos = 3'd4;
		msg_open = 1'b1;
	endfunction

	function void note_input(bit [63:0] data, bit [3:0] cnt, bit last);
		bit [3:0]     n;
		bit [63:0]    mask;
		cipher_word_t e;
		n = (cnt == 4'd0 || cnt > 4'd8) ? 4'd8 : cnt;
		mask = (n == 4'd8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
		if (!msg_open)
			open_msg();
		e.word = (data ^ stream_blk[word_pos]) & mask;
		e.count = n;
		e.last = last;
		owed_q.push_back(e);
		// Advance a full word even on a partial one
		word_pos = word_pos + 3'd1;
		if (last) begin
			msg_open = 1'b0;
		end else if (word_pos == 3'd0) begin
			refill(next_ctr);
			next_ctr = next_ctr + 32'd1;
		end
	endfunction

	function void check_result(bit [63:0] word, bit [3:0] cnt, bit last);
		cipher_word_t e;
		if (owed_q.size() == 0) begin
			errors++;
			if (errors <= 30)
				$display("%0t: unexpected result word %h count %0d last %0b",
					$time, word, cnt, last);
			return;
		end
		e = owed_q.pop_front();
		checked++;
		if (e.word !== word || e.count !== cnt || e.last !== last) begin
			errors++;
			if (errors <= 30)
				$display("%0t: result mismatch: expected %h/%0d/%0b, actual %h/%0d/%0b",
					$time, e.word, e.count, e.last, word, cnt, last);
		end
	endfunction

	function int pending();
		return owed_q.size();
	endfunction
endclass

module tb;
	logic clk;
	logic arst_n;

	xsb_cfg_if cfg_ch ();
	xsb_in_if  msg_ch ();
	xsb_out_if res_ch ();

	xsalsa20_box_stream_cipher_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.message (msg_ch),
		.result  (res_ch)
	);

	keystream_scoreboard sb = new;

	int items_sent;
	int reg_writes;
	int msg_total;
	bit calm;
	int hold_request;
	int stall_left;

	const cfg_reg_t all_regs [7] = '{CFG_SECRET0, CFG_SECRET1, CFG_SECRET2, CFG_SECRET3,
		CFG_NONCE0, CFG_NONCE1, CFG_NONCE2};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Drive every input known from time zero; hold reset, then release it
	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_SECRET0;
		cfg_ch.data = '0;
		msg_ch.valid = 1'b0;
		msg_ch.data_word = '0;
		msg_ch.byte_count = '0;
		msg_ch.last_word = 1'b0;
		res_ch.ready = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_ch.ready = 1'b0;
			stall_left--;
		end else if (hold_request > 0) begin
			stall_left = hold_request - 1;
			hold_request = 0;
			res_ch.ready = 1'b0;
		end else begin
			res_ch.ready = calm || ($urandom_range(99) >= 38);
		end
	end

	// Observe handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.set_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
			if (msg_ch.valid && msg_ch.ready)
				sb.note_input(msg_ch.data_word, msg_ch.byte_count, msg_ch.last_word);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.result_word, res_ch.result_count,
					res_ch.result_last);
		end
	end

	function automatic bit [63:0] rand_data();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Offer one item, with random idle cycles ahead of it; called at a falling edge
	task automatic send_word(bit [63:0] data, bit [3:0] cnt, bit last);
		while (!calm && $urandom_range(99) < 38) begin
			msg_ch.valid = 1'b0;
			@(negedge clk);
		end
		msg_ch.valid = 1'b1;
		msg_ch.data_word = data;
		msg_ch.byte_count = cnt;
		msg_ch.last_word = last;
		do @(posedge clk); while (msg_ch.ready !== 1'b1);
		@(negedge clk);
		items_sent++;
		if (last)
			msg_total++;
	endtask

	task automatic write_reg(cfg_reg_t idx, bit [63:0] v);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		reg_writes++;
	endtask

	// Drop the input and wait for every owed result
	task automatic wait_drained();
		msg_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Bound the run
	initial begin
		#50000000;
		$display("tb: errors");
		$finish;
	end

	initial begin
		int len;
		int split;
		int phase;
		bit [3:0] cnt;
		bit lst;
		bit [63:0] fill;

		@(posedge arst_n);
		@(negedge clk);

		// Reset registers: extremes of data and byte count, two block crossings
		send_word('0, 4'd8, 1'b0);
		send_word('1, 4'd8, 1'b0);
		send_word(rand_data(), 4'd0, 1'b0);
		send_word(rand_data(), 4'd15, 1'b0);
		send_word(rand_data(), 4'd9, 1'b0);
		send_word(rand_data(), 4'd3, 1'b0);
		send_word(rand_data(), 4'd1, 1'b0);
		send_word(rand_data(), 4'd7, 1'b0);
		send_word('1, 4'd8, 1'b0);
		send_word(rand_data(), 4'd10, 1'b0);
		send_word(rand_data(), 4'd8, 1'b0);
		send_word(rand_data(), 4'd2, 1'b0);
		send_word('1, 4'd4, 1'b0);
		send_word(rand_data(), 4'd6, 1'b0);
		send_word(rand_data(), 4'd5, 1'b1);
		wait_drained();

		// All-ones secret and nonce, one-word message
		foreach (all_regs[i])
			write_reg(all_regs[i], '1);
		send_word('1, 4'd8, 1'b1);
		wait_drained();

		// Random registers, short message ending on a partial word
		foreach (all_regs[i])
			write_reg(all_regs[i], {$urandom, $urandom});
		send_word(rand_data(), 4'd8, 1'b0);
		send_word(rand_data(), 4'd11, 1'b0);
		send_word(rand_data(), 4'd8, 1'b0);
		send_word(rand_data(), 4'd8, 1'b0);
		send_word(rand_data(), 4'd2, 1'b1);
		wait_drained();

		// Random messages, each starting from a drained unit
		phase = 0;
		while (items_sent < 2000) begin
			calm = (phase >= 20 && phase < 30);

			// Register settings between messages, extremes now and then
			if ($urandom_range(9) == 0) begin
				fill = $urandom_range(1) ? '1 : '0;
				foreach (all_regs[i])
					write_reg(all_regs[i], fill);
			end else if ($urandom_range(1) == 0) begin
				foreach (all_regs[i])
					if ($urandom_range(99) < 40)
						write_reg(all_regs[i], rand_data());
			end

			case ($urandom_range(9))
				0: len = 1;
				1, 2: len = $urandom_range(41, 80);
				default: len = $urandom_range(2, 40);
			endcase
			// Long receiver hold-off while words keep coming
			if (phase == 8 || phase == 40) begin
				len = 60;
				hold_request = 5000;
			end
			split = (len > 10 && $urandom_range(4) == 0) ? $urandom_range(1, len - 1) : 0;

			for (int w = 0; w < len; w++) begin
				// Mid-message writes once the unit has settled: later blocks see nonce word 2
				if (split != 0 && w == split) begin
					wait_drained();
					repeat (1200) @(negedge clk);
					write_reg(CFG_NONCE2, rand_data());
					if ($urandom_range(1))
						write_reg(all_regs[$urandom_range(5)], rand_data());
				end
				lst = (w == len - 1);
				cnt = lst ? 4'($urandom_range(1, 8)) : 4'd8;
				if ($urandom_range(99) < 15)
					cnt = 4'($urandom_range(15));
				send_word(rand_data(), cnt, lst);
			end
			wait_drained();
			phase++;
		end

		// Watch for stray results, then report
		calm = 1'b0;
		wait_drained();
		repeat (1100) @(negedge clk);
		sb.errors += sb.pending();
		$display("summary: %0d items in %0d messages, %0d register writes, %0d results checked",
			items_sent, msg_total, reg_writes, sb.checked);
		if (sb.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
